[hw/rtl/tapc_pkg.sv]
package tapc_pkg;

    localparam int POS_BITS_DEF      = 16;
    localparam int GAIN_BITS_DEF     = 20;
    localparam int INTEGRAL_BITS_DEF = 32;

    // register indexes
    localparam logic [2:0] REG_GP_XY  = 3'd0;
    localparam logic [2:0] REG_GI_XY  = 3'd1;
    localparam logic [2:0] REG_GD_XY  = 3'd2;
    localparam logic [2:0] REG_GP_Z   = 3'd3;
    localparam logic [2:0] REG_GI_Z   = 3'd4;
    localparam logic [2:0] REG_GD_Z   = 3'd5;
    localparam logic [2:0] REG_SPEED  = 3'd6;
    localparam logic [2:0] REG_RADIUS = 3'd7;

    localparam int          TERM_SHIFT = 16;
    localparam logic [63:0] TERM_MAX   = 64'h0000_0100_0000_0000;
    localparam logic [15:0] MS_SCALE   = 16'd1000;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } t_state;

    // one term request to the shared multiply/divide unit
    typedef struct packed {
        logic        start;
        logic [63:0] mag;
        logic [31:0] gain;
        logic [15:0] divisor;
    } t_term_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_term_rsp;

endpackage

[hw/rtl/three_axis_pid_position_control.sv]
// Three-axis PID position controller. Each accepted tick yields one result of
// clamped X/Y/Z velocity commands plus arrived and publish flags. PID terms go
// one at a time through a single shift-add multiplier and restoring divider.
// A running tick with a valid measurement runs nine terms; on the first step
// the three derivative terms are skipped. Stopped or lost-marker ticks give
// their result on the cycle after the transfer. No new tick is taken until
// the result has been transferred. Configuration writes are always taken and
// belong between ticks.
module three_axis_pid_position_control #(
    parameter int POS_BITS      = tapc_pkg::POS_BITS_DEF,
    parameter int GAIN_BITS     = tapc_pkg::GAIN_BITS_DEF,
    parameter int INTEGRAL_BITS = tapc_pkg::INTEGRAL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [POS_BITS-1:0]  i_meas_x,
    input  logic signed [POS_BITS-1:0]  i_meas_y,
    input  logic signed [POS_BITS-1:0]  i_meas_z,
    input  logic                        i_meas_valid,
    input  logic signed [POS_BITS-1:0]  i_goal_x,
    input  logic signed [POS_BITS-1:0]  i_goal_y,
    input  logic signed [POS_BITS-1:0]  i_goal_z,
    input  logic                        i_run_enable,
    input  logic [15:0]                 i_elapsed_ms,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [15:0]          o_vel_x,
    output logic signed [15:0]          o_vel_y,
    output logic signed [15:0]          o_vel_z,
    output logic                        o_arrived,
    output logic                        o_publish
);

    localparam int EB = POS_BITS + 1;
    localparam logic signed [INTEGRAL_BITS-1:0] IMAX =
        {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    localparam logic signed [INTEGRAL_BITS-1:0] IMIN = ~IMAX;

    // configuration registers
    logic [GAIN_BITS-1:0] r_gain [6];
    logic [14:0]          r_speed;
    logic [13:0]          r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_gain[k] <= GAIN_BITS'(655);
            r_speed  <= 15'd2048;
            r_radius <= 14'd614;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tapc_pkg::REG_SPEED:  r_speed  <= i_cfg_data[14:0];
                tapc_pkg::REG_RADIUS: r_radius <= i_cfg_data[13:0];
                default: r_gain[i_cfg_index] <= i_cfg_data[GAIN_BITS-1:0];
            endcase
        end
    end

    // controller state
    logic signed [POS_BITS-1:0]      r_held [3];
    logic signed [EB-1:0]            r_prev [3];
    logic signed [INTEGRAL_BITS-1:0] r_integ [3];
    logic                            r_first;

    // per-tick working registers
    tapc_pkg::t_state           r_state, n_state;
    tapc_pkg::t_state           n_state_f;
    logic signed [EB-1:0]       r_err [3];
    logic [15:0]                r_dt;
    logic [1:0]                 r_axis;
    logic [1:0]                 r_kind;
    logic signed [63:0]         r_cmd;
    logic signed [15:0]         r_vel [3];
    logic                       r_arr, r_pub, r_ovalid;

    tapc_pkg::t_term_req req;
    tapc_pkg::t_term_rsp rsp;

    tapc_term_unit u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    logic accept;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != tapc_pkg::ST_IDLE) || r_ovalid;

    // operand for the current term
    logic signed [66:0] opnd;
    logic               neg;
    logic [2:0]         gidx;
    always_comb begin
        unique case (r_kind)
            2'd0:    opnd = 67'(r_err[r_axis]);
            2'd1:    opnd = 67'(r_integ[r_axis]);
            default: opnd = (67'(r_err[r_axis]) - 67'(r_prev[r_axis])) * 67'sd1000;
        endcase
        neg  = opnd < 0;
        gidx = (r_axis == 2'd2) ? 3'(3 + r_kind) : 3'(r_kind);
        req.start   = (r_state == tapc_pkg::ST_MUL);
        req.mag     = neg ? 64'(-opnd) : 64'(opnd);
        req.gain    = 32'(r_gain[gidx]);
        req.divisor = (r_kind == 2'd0) ? 16'd1 :
                      (r_kind == 2'd1) ? tapc_pkg::MS_SCALE : r_dt;
        n_state = r_state;
        unique case (r_state)
            tapc_pkg::ST_IDLE: n_state = r_state;
            tapc_pkg::ST_MUL:  n_state = tapc_pkg::ST_DIV;
            tapc_pkg::ST_DIV:  if (rsp.done) n_state = tapc_pkg::ST_SUM;
            tapc_pkg::ST_SUM:  n_state = tapc_pkg::ST_MUL;
            tapc_pkg::ST_OUT:  n_state = tapc_pkg::ST_IDLE;
            default:           n_state = tapc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tapc_pkg::ST_IDLE;
        else          r_state <= n_state_f;
    end

    // final state choice including tick entry and loop end
    logic last_term;
    assign last_term = (r_axis == 2'd2) && (r_kind == 2'd2 || (r_kind == 2'd1 && r_first));
    always_comb begin
        n_state_f = n_state;
        if (r_state == tapc_pkg::ST_IDLE && accept && i_run_enable && i_meas_valid)
            n_state_f = tapc_pkg::ST_MUL;
        else if (r_state == tapc_pkg::ST_SUM && last_term)
            n_state_f = tapc_pkg::ST_OUT;
    end

    logic signed [POS_BITS-1:0] hx, hy, hz;
    logic signed [INTEGRAL_BITS+EB+17:0] s_new;
    logic signed [63:0] t_signed, c_fin, lim;
    logic [EB-1:0] ax, ay, az;
    logic [15:0] dtc;

    always_comb begin
        hx = i_meas_valid ? i_meas_x : r_held[0];
        hy = i_meas_valid ? i_meas_y : r_held[1];
        hz = i_meas_valid ? i_meas_z : r_held[2];
        dtc = (i_elapsed_ms == 16'd0) ? 16'd1 : i_elapsed_ms;
        s_new = $signed(r_integ[r_axis]) + r_err[r_axis] * $signed({1'b0, r_dt});
        t_signed = neg ? -$signed(rsp.result) : $signed(rsp.result);
        c_fin = (r_axis == 2'd0) ? -(r_cmd + t_signed) : (r_cmd + t_signed);
        lim = 64'(r_speed);
        ax = r_err[0][EB-1] ? EB'(-r_err[0]) : EB'(r_err[0]);
        ay = r_err[1][EB-1] ? EB'(-r_err[1]) : EB'(r_err[1]);
        az = r_err[2][EB-1] ? EB'(-r_err[2]) : EB'(r_err[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_held[k]  <= '0;
                r_prev[k]  <= '0;
                r_integ[k] <= '0;
            end
            r_first  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (accept) begin
                if (i_meas_valid) begin
                    r_held[0] <= i_meas_x;
                    r_held[1] <= i_meas_y;
                    r_held[2] <= i_meas_z;
                end
                r_err[0] <= EB'(hx) - EB'(i_goal_x);
                r_err[1] <= EB'(hy) - EB'(i_goal_y);
                r_err[2] <= EB'(hz) - EB'(i_goal_z);
                r_dt   <= dtc;
                r_axis <= 2'd0;
                r_kind <= 2'd0;
                r_cmd  <= '0;
                for (int k = 0; k < 3; k++) r_vel[k] <= '0;
                r_arr <= 1'b0;
                r_pub <= i_run_enable;
                if (!i_run_enable) begin
                    for (int k = 0; k < 3; k++) begin
                        r_prev[k]  <= '0;
                        r_integ[k] <= '0;
                    end
                    r_first  <= 1'b1;
                    r_ovalid <= 1'b1;
                end else if (!i_meas_valid) begin
                    r_prev[0] <= EB'(hx) - EB'(i_goal_x);
                    r_prev[1] <= EB'(hy) - EB'(i_goal_y);
                    r_prev[2] <= EB'(hz) - EB'(i_goal_z);
                    r_first  <= 1'b0;
                    r_ovalid <= 1'b1;
                end
            end
            // integral update before the integral term of each axis
            if (r_state == tapc_pkg::ST_MUL && r_kind == 2'd0) begin
                if (s_new > IMAX)      r_integ[r_axis] <= IMAX;
                else if (s_new < IMIN) r_integ[r_axis] <= IMIN;
                else r_integ[r_axis] <= s_new[INTEGRAL_BITS-1:0];
            end
            if (r_state == tapc_pkg::ST_SUM) begin
                if (r_kind == 2'd2 || (r_kind == 2'd1 && r_first)) begin
                    if (c_fin > lim)       r_vel[r_axis] <= 16'(lim);
                    else if (c_fin < -lim) r_vel[r_axis] <= 16'(-lim);
                    else                   r_vel[r_axis] <= c_fin[15:0];
                    r_cmd  <= '0;
                    r_kind <= 2'd0;
                    r_axis <= r_axis + 2'd1;
                end else begin
                    r_cmd  <= r_cmd + t_signed;
                    r_kind <= r_kind + 2'd1;
                end
            end
            if (r_state == tapc_pkg::ST_OUT) begin
                if (ax < EB'(r_radius) && ay < EB'(r_radius) &&
                    az < (EB'(r_radius) << 1)) begin
                    r_arr <= 1'b1;
                    for (int k = 0; k < 3; k++) r_vel[k] <= '0;
                end
                for (int k = 0; k < 3; k++) r_prev[k] <= r_err[k];
                r_first  <= 1'b0;
                r_ovalid <= 1'b1;
            end
        end
    end

    assign o_valid   = r_ovalid;
    assign o_vel_x   = r_vel[0];
    assign o_vel_y   = r_vel[1];
    assign o_vel_z   = r_vel[2];
    assign o_arrived = r_arr;
    assign o_publish = r_pub;

endmodule

[hw/rtl/tapc_term_unit.sv]
// Term magnitude: min(((gain * mag) saturated at 2^64-1 / div) >> 16, 2^40).
// Multiply is shift-add, one bit a cycle; divide is restoring, one bit a cycle.
module tapc_term_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tapc_pkg::t_term_req   i_req,
    output tapc_pkg::t_term_rsp   o_rsp
);

    logic [1:0]  r_phase, n_phase;
    logic [6:0]  r_cnt, n_cnt;
    logic [95:0] r_prod, n_prod;
    logic [31:0] r_gain, n_gain;
    logic [63:0] r_mag, n_mag;
    logic [15:0] r_div, n_div;
    logic [63:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic        r_done, n_done;
    logic [16:0] rem_sh;
    logic [63:0] q_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_cnt  <= n_cnt;
        r_prod <= n_prod;
        r_gain <= n_gain;
        r_mag  <= n_mag;
        r_div  <= n_div;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
    end

    // phase 0 idle, 1 multiply, 2 divide
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_gain  = r_gain;
        n_mag   = r_mag;
        n_div   = r_div;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_done  = 1'b0;
        rem_sh  = {r_rem[15:0], r_quo[63]};
        q_sh    = {r_quo[62:0], 1'b0};
        unique case (r_phase)
            2'd1: begin
                if (r_gain[0]) begin
                    n_prod = r_prod + ({32'd0, r_mag} << r_cnt[4:0]);
                end
                n_gain = {1'b0, r_gain[31:1]};
                n_cnt  = r_cnt + 7'd1;
                if (r_cnt == 7'd31) begin
                    n_phase = 2'd2;
                    n_cnt   = 7'd0;
                    n_rem   = '0;
                    n_quo   = (n_prod[95:64] != 32'd0) ? '1 : n_prod[63:0];
                end
            end
            2'd2: begin
                if (rem_sh >= {1'b0, r_div}) begin
                    n_rem = rem_sh - {1'b0, r_div};
                    n_quo = {q_sh[63:1], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = q_sh;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_phase = 2'd0;
                    n_done  = 1'b1;
                end
            end
            default: begin
                if (i_req.start) begin
                    n_phase = 2'd1;
                    n_cnt   = 7'd0;
                    n_prod  = '0;
                    n_gain  = i_req.gain;
                    n_mag   = i_req.mag;
                    n_div   = i_req.divisor;
                end
            end
        endcase
    end

    always_comb begin
        logic [63:0] sh;
        sh = r_quo >> tapc_pkg::TERM_SHIFT;
        o_rsp.done   = r_done;
        o_rsp.result = (sh > tapc_pkg::TERM_MAX) ? tapc_pkg::TERM_MAX : sh;
    end

endmodule

[test/three_axis_pid_position_control_tb.sv]
`timescale 1ns / 100ps

module three_axis_pid_position_control_tb;

    localparam longint IMAX = 64'sd2147483647;
    localparam longint IMIN = -64'sd2147483648;

    typedef struct {
        logic signed [15:0] mx, my, mz;
        logic               mv;
        logic signed [15:0] gx, gy, gz;
        logic               run;
        logic [15:0]        ms;
    } t_tick;

    typedef struct {
        logic signed [15:0] vx, vy, vz;
        logic               arrived;
        logic               publish;
    } t_cmd;

    logic               i_clk, i_rst_n;
    logic               i_cfg_valid, o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid, o_stall;
    logic signed [15:0] i_meas_x, i_meas_y, i_meas_z;
    logic               i_meas_valid;
    logic signed [15:0] i_goal_x, i_goal_y, i_goal_z;
    logic               i_run_enable;
    logic [15:0]        i_elapsed_ms;
    logic               o_valid, i_stall;
    logic signed [15:0] o_vel_x, o_vel_y, o_vel_z;
    logic               o_arrived, o_publish;

    three_axis_pid_position_control dut (.*);

    // controller copy: registers and per-axis history
    longint unsigned gp_xy, gi_xy, gd_xy, gp_z, gi_z, gd_z, spd_lim, radius;
    longint          pos_hold[3], err_last[3], err_sum[3];
    bit              first_tick;

    t_cmd expected_cmds[$];
    int   errors = 0;
    bit   calm = 0;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("three_axis_pid_position_control_tb NOT OK");
        $finish;
    end

    // one PID term, on magnitudes, rounded toward zero
    function automatic longint pid_term(longint unsigned g, longint x, longint unsigned dv);
        longint unsigned m, p;
        m = (x < 0) ? -x : x;
        if (m != 0 && g > 64'hFFFF_FFFF_FFFF_FFFF / m) p = 64'hFFFF_FFFF_FFFF_FFFF;
        else p = g * m;
        p = (p / dv) >> 16;
        if (p > tapc_pkg::TERM_MAX) p = tapc_pkg::TERM_MAX;
        return (x < 0) ? -longint'(p) : longint'(p);
    endfunction

    task automatic predict_cmd(input t_tick t);
        longint e[3], goal[3], s, c, lim;
        longint unsigned dt, g_p, g_i, g_d;
        t_cmd r;
        dt = (t.ms == 0) ? 1 : t.ms;
        if (t.mv) begin
            pos_hold[0] = t.mx; pos_hold[1] = t.my; pos_hold[2] = t.mz;
        end
        goal[0] = t.gx; goal[1] = t.gy; goal[2] = t.gz;
        for (int a = 0; a < 3; a++) e[a] = pos_hold[a] - goal[a];
        r = '{0, 0, 0, 0, 0};
        if (!t.run) begin
            for (int a = 0; a < 3; a++) begin
                err_last[a] = 0;
                err_sum[a] = 0;
            end
            first_tick = 1;
            expected_cmds.push_back(r);
            return;
        end
        r.publish = 1;
        if (t.mv) begin
            lim = spd_lim;
            for (int a = 0; a < 3; a++) begin
                g_p = (a == 2) ? gp_z : gp_xy;
                g_i = (a == 2) ? gi_z : gi_xy;
                g_d = (a == 2) ? gd_z : gd_xy;
                s = err_sum[a] + e[a] * longint'(dt);
                if (s > IMAX) s = IMAX;
                if (s < IMIN) s = IMIN;
                err_sum[a] = s;
                c = pid_term(g_p, e[a], 1) + pid_term(g_i, s, 1000);
                if (!first_tick) c += pid_term(g_d, (e[a] - err_last[a]) * 1000, dt);
                if (a == 0) c = -c;
                if (c > lim) c = lim;
                if (c < -lim) c = -lim;
                if (a == 0) r.vx = 16'(c); else if (a == 1) r.vy = 16'(c); else r.vz = 16'(c);
            end
            if ((e[0] < 0 ? -e[0] : e[0]) < longint'(radius) &&
                (e[1] < 0 ? -e[1] : e[1]) < longint'(radius) &&
                (e[2] < 0 ? -e[2] : e[2]) < 2 * longint'(radius)) begin
                r.arrived = 1;
                r.vx = 0; r.vy = 0; r.vz = 0;
            end
        end
        for (int a = 0; a < 3; a++) err_last[a] = e[a];
        first_tick = 0;
        expected_cmds.push_back(r);
    endtask

    // output side: random stall, compare each transfer
    always @(negedge i_clk) begin
        if (i_rst_n) i_stall <= calm ? 1'b0 : ($urandom_range(99) < 11);
    end

    always @(posedge i_clk) begin
        t_cmd x;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cmds.size() == 0) begin
                $display("%0t: result with nothing expected: %0d %0d %0d %b %b", $time,
                         o_vel_x, o_vel_y, o_vel_z, o_arrived, o_publish);
                errors++;
            end else begin
                x = expected_cmds.pop_front();
                if (o_vel_x !== x.vx || o_vel_y !== x.vy || o_vel_z !== x.vz ||
                    o_arrived !== x.arrived || o_publish !== x.publish) begin
                    $display("%0t: expected %0d %0d %0d arr %b pub %b, got %0d %0d %0d arr %b pub %b",
                             $time, x.vx, x.vy, x.vz, x.arrived, x.publish,
                             o_vel_x, o_vel_y, o_vel_z, o_arrived, o_publish);
                    errors++;
                end
            end
        end
    end

    task automatic send_tick(input t_tick t);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 11) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_meas_x <= t.mx; i_meas_y <= t.my; i_meas_z <= t.mz; i_meas_valid <= t.mv;
        i_goal_x <= t.gx; i_goal_y <= t.gy; i_goal_z <= t.gz;
        i_run_enable <= t.run; i_elapsed_ms <= t.ms;
        i_valid <= 1;
        do @(posedge i_clk); while (o_stall);
        predict_cmd(t);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        wait (expected_cmds.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tapc_pkg::REG_GP_XY:  gp_xy = val[19:0];
            tapc_pkg::REG_GI_XY:  gi_xy = val[19:0];
            tapc_pkg::REG_GD_XY:  gd_xy = val[19:0];
            tapc_pkg::REG_GP_Z:   gp_z = val[19:0];
            tapc_pkg::REG_GI_Z:   gi_z = val[19:0];
            tapc_pkg::REG_GD_Z:   gd_z = val[19:0];
            tapc_pkg::REG_SPEED:  spd_lim = val[14:0];
            tapc_pkg::REG_RADIUS: radius = val[13:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic set_all(input logic [31:0] g, input logic [31:0] spd, input logic [31:0] rad);
        drain();
        write_reg(tapc_pkg::REG_GP_XY, g);
        write_reg(tapc_pkg::REG_GI_XY, g);
        write_reg(tapc_pkg::REG_GD_XY, g);
        write_reg(tapc_pkg::REG_GP_Z, g);
        write_reg(tapc_pkg::REG_GI_Z, g);
        write_reg(tapc_pkg::REG_GD_Z, g);
        write_reg(tapc_pkg::REG_SPEED, spd);
        write_reg(tapc_pkg::REG_RADIUS, rad);
    endtask

    // mostly near the goal, sometimes anywhere in range
    function automatic t_tick rand_tick(input int spread);
        t_tick t;
        t.mx = 16'($urandom); t.my = 16'($urandom); t.mz = 16'($urandom);
        if ($urandom_range(3) != 0) begin
            t.gx = 16'(t.mx + $signed($urandom_range(2 * spread)) - spread);
            t.gy = 16'(t.my + $signed($urandom_range(2 * spread)) - spread);
            t.gz = 16'(t.mz + $signed($urandom_range(2 * spread)) - spread);
        end else begin
            t.gx = 16'($urandom); t.gy = 16'($urandom); t.gz = 16'($urandom);
        end
        t.mv = ($urandom_range(9) != 0);
        t.run = ($urandom_range(19) != 0);
        case ($urandom_range(3))
            0: t.ms = 16'($urandom);
            1: t.ms = 16'($urandom_range(3));
            default: t.ms = 16'($urandom_range(50, 200));
        endcase
        return t;
    endfunction

    task automatic test_directed();
        t_tick t;
        t = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, -16'sh8000, -16'sh8000, -16'sh8000, 1, 100};
        send_tick(t);                       // first step, largest error
        t.ms = 16'hFFFF; send_tick(t);
        t.ms = 0; send_tick(t);             // zero elapsed treated as one
        t = '{-16'sh8000, -16'sh8000, -16'sh8000, 1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, 1};
        send_tick(t);
        t.mv = 0; send_tick(t);             // lost marker
        t.run = 0; t.mv = 1; send_tick(t);  // stopped, held position still updated
        t = '{16'sd100, -16'sd100, 16'sd300, 1, 16'sd0, 16'sd0, 16'sd0, 1, 100};
        send_tick(t);                       // inside arrival box
        t.mz = 16'sd1300; send_tick(t);     // Z just outside
        t.mz = 16'sd1227; send_tick(t);
        t.mx = 16'sd614; send_tick(t);      // X on the edge
        t.mx = -16'sd613; send_tick(t);
        t = '{16'sd4000, 16'sd0, 16'sd0, 1, 16'sd0, 16'sd0, 16'sd0, 1, 100};
        for (int i = 0; i < 6; i++) send_tick(t);   // integral builds up
        t.run = 0; t.mv = 0; send_tick(t);
        t.run = 1; send_tick(t);
    endtask

    task automatic test_config_extremes();
        set_all(32'hFFFF_FFFF, 32'h0000_7FFF, 32'h0000_3FFF);
        for (int i = 0; i < 40; i++) send_tick(rand_tick(20000));
        set_all(0, 0, 0);
        for (int i = 0; i < 40; i++) send_tick(rand_tick(2000));
        set_all(32'h000F_FFFF, 32'h7FFF, 0);
        for (int i = 0; i < 40; i++) send_tick(rand_tick(500));
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(tapc_pkg::REG_GP_XY, $urandom_range(1 << 20));
            write_reg(tapc_pkg::REG_GI_XY, $urandom_range(1 << 16));
            write_reg(tapc_pkg::REG_GD_XY, $urandom_range(1 << 14));
            write_reg(tapc_pkg::REG_GP_Z, $urandom);
            write_reg(tapc_pkg::REG_GI_Z, $urandom_range(1 << 12));
            write_reg(tapc_pkg::REG_GD_Z, $urandom_range(1 << 18));
            write_reg(tapc_pkg::REG_SPEED, $urandom_range(32767));
            write_reg(tapc_pkg::REG_RADIUS, $urandom_range(3000));
            calm = (ph == 3);
            for (int i = 0; i < 280; i++) begin
                if (i == 140) drain();      // sender waits for every result
                send_tick(rand_tick(ph[0] ? 800 : 8000));
            end
            calm = 0;
        end
    endtask

    initial begin
        i_rst_n = 0; i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_valid = 0; i_stall = 0;
        i_meas_x = 0; i_meas_y = 0; i_meas_z = 0; i_meas_valid = 0;
        i_goal_x = 0; i_goal_y = 0; i_goal_z = 0; i_run_enable = 0; i_elapsed_ms = 0;
        gp_xy = 655; gi_xy = 655; gd_xy = 655; gp_z = 655; gi_z = 655; gd_z = 655;
        spd_lim = 2048; radius = 614; first_tick = 1;
        for (int a = 0; a < 3; a++) begin
            pos_hold[a] = 0; err_last[a] = 0; err_sum[a] = 0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_config_extremes();
        test_random();
        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("three_axis_pid_position_control_tb OK");
        end else begin
            $display("three_axis_pid_position_control_tb NOT OK");
        end
        $finish;
    end

endmodule
